// ===== hdl/bfd_pkg.sv =====
`default_nettype none

package bfd_pkg;

  localparam int unsigned BFD_DEPTH      = 64;
  localparam int unsigned BFD_ITEM_WIDTH = 32;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;

  localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NO_SLOT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_NEWEST = 2'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   item_in;
    logic [SLOT_W-1:0]   slot_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   item_out;
    logic [SLOT_W-1:0]   slot_out;
    logic                dropped_valid;
    logic [WORD_W-1:0]   dropped_item;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic rd_issue;
    logic skip;
    logic fin_exec;
    logic fin_read;
  } cmd_t;

  typedef struct packed {
    logic need_read;
    logic skip;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/bfd_ctrl.sv =====
`default_nettype none

module bfd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire bfd_pkg::sts_t sts_i,
  output bfd_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.need_read) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_READ;
        end else if (out_free) begin
          cmd_o.fin_exec = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts_i.skip) begin
          cmd_o.skip = 1'b1;
        end else if (out_free) begin
          cmd_o.fin_read = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin_exec || cmd_o.fin_read) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bfd_datapath.sv =====
`default_nettype none

module bfd_datapath #(
  parameter int unsigned DEPTH      = bfd_pkg::BFD_DEPTH,
  parameter int unsigned ITEM_WIDTH = bfd_pkg::BFD_ITEM_WIDTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bfd_pkg::in_item_t                   in_data_i,
  output bfd_pkg::out_item_t                       out_data_o,
  input  wire logic                                cfg_valid_i,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire bfd_pkg::cmd_t                       cmd_i,
  output bfd_pkg::sts_t                            sts_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned LW = (CW > bfd_pkg::COUNT_W) ? CW : bfd_pkg::COUNT_W;
  localparam int unsigned SW = PW + bfd_pkg::SLOT_W + 1;
  localparam logic [PW-1:0] LAST_POS  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CW  = CW'(DEPTH);
  localparam logic [LW-1:0] DEPTH_LW  = LW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SW  = SW'(DEPTH);

  logic [ITEM_WIDTH-1:0] item_mem [DEPTH];
  logic                  aband_mem [DEPTH];

  bfd_pkg::in_item_t  req_q;
  bfd_pkg::out_item_t out_q, res;

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [bfd_pkg::COUNT_W-1:0] size_limit_q;
  logic          drop_newest_q;

  logic [ITEM_WIDTH-1:0] rd_item_q;
  logic                  rd_aband_q;

  logic                  rd_en, wr_en, ab_we, ab_wd;
  logic [PW-1:0]         rd_addr, wr_addr, ab_addr;
  logic [ITEM_WIDTH-1:0] wr_item;

  logic is_push, is_pop, full, occupied;
  logic [PW-1:0] head_nx, tail_nx, tail_pv, victim, slot_idx, slot_pick;
  logic [LW-1:0] sl_ext, lim;
  logic [SW-1:0] slot_wide;
  logic [PW:0]   diff, span;
  logic [ITEM_WIDTH+bfd_pkg::WORD_W-1:0] in_ext, rd_ext;
  logic [PW+bfd_pkg::SLOT_W-1:0]         slot_ext;
  logic [CW+bfd_pkg::COUNT_W-1:0]        cnt_ext;

  assign is_push = (req_q.action == bfd_pkg::ACT_PUSH);
  assign is_pop  = (req_q.action == bfd_pkg::ACT_POP);

  assign head_nx = (head_q == LAST_POS) ? '0 : head_q + PW'(1);
  assign tail_nx = (tail_q == LAST_POS) ? '0 : tail_q + PW'(1);
  assign tail_pv = (tail_q == '0) ? LAST_POS : tail_q - PW'(1);
  assign victim  = drop_newest_q ? tail_pv : head_q;

  // limit of zero or above the depth means the whole ring
  assign sl_ext = LW'(size_limit_q);
  assign lim    = (sl_ext == '0 || sl_ext > DEPTH_LW) ? DEPTH_LW : sl_ext;
  assign full   = (LW'(cnt_q) >= lim) && (cnt_q != '0);

  // a slot is queued when it lies within the ring window from the head
  assign slot_wide = SW'(req_q.slot_in);
  assign slot_idx  = slot_wide[PW-1:0];
  assign diff      = {1'b0, slot_idx} - {1'b0, head_q};
  assign span      = diff[PW] ? diff + DEPTH_CW : diff;
  assign occupied  = (slot_wide < DEPTH_SW) && (span < cnt_q);

  assign in_ext  = {{ITEM_WIDTH{1'b0}}, req_q.item_in};
  assign wr_item = in_ext[ITEM_WIDTH-1:0];
  assign rd_ext  = {{bfd_pkg::WORD_W{1'b0}}, rd_item_q};

  assign sts_o.need_read = (is_push && full) || (is_pop && cnt_q != '0);
  assign sts_o.skip      = is_pop && rd_aband_q && (cnt_q > CW'(1));

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    wr_en     = 1'b0;
    wr_addr   = tail_q;
    ab_we     = 1'b0;
    ab_wd     = 1'b0;
    ab_addr   = tail_q;
    slot_pick = '0;
    res       = '0;
    res.status = bfd_pkg::STS_DONE;

    if (cmd_i.rd_issue) begin
      rd_en   = 1'b1;
      rd_addr = is_push ? victim : head_q;
    end

    if (cmd_i.skip) begin
      head_d  = head_nx;
      cnt_d   = cnt_q - CW'(1);
      rd_en   = 1'b1;
      rd_addr = head_nx;
    end

    if (cmd_i.fin_exec) begin
      unique case (req_q.action)
        bfd_pkg::ACT_PUSH: begin
          wr_en     = 1'b1;
          ab_we     = 1'b1;
          slot_pick = tail_q;
          tail_d    = tail_nx;
          cnt_d     = cnt_q + CW'(1);
        end
        bfd_pkg::ACT_POP: begin
          res.status = bfd_pkg::STS_EMPTY;
        end
        bfd_pkg::ACT_CANCEL: begin
          if (occupied) begin
            ab_we   = 1'b1;
            ab_wd   = 1'b1;
            ab_addr = slot_idx;
          end else begin
            res.status = bfd_pkg::STS_NO_SLOT;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.fin_read) begin
      if (is_push) begin
        res.dropped_valid = 1'b1;
        res.dropped_item  = rd_ext[bfd_pkg::WORD_W-1:0];
        wr_en = 1'b1;
        ab_we = 1'b1;
        if (drop_newest_q) begin
          // new item takes over the slot of the dropped newest entry
          wr_addr   = tail_pv;
          ab_addr   = tail_pv;
          slot_pick = tail_pv;
        end else begin
          head_d    = head_nx;
          slot_pick = tail_q;
          tail_d    = tail_nx;
        end
      end else begin
        head_d = head_nx;
        cnt_d  = cnt_q - CW'(1);
        if (rd_aband_q) begin
          res.status = bfd_pkg::STS_EMPTY;
        end else begin
          res.item_out = rd_ext[bfd_pkg::WORD_W-1:0];
        end
      end
    end

    slot_ext        = {{bfd_pkg::SLOT_W{1'b0}}, slot_pick};
    cnt_ext         = {{bfd_pkg::COUNT_W{1'b0}}, cnt_d};
    res.slot_out    = slot_ext[bfd_pkg::SLOT_W-1:0];
    res.entry_count = cnt_ext[bfd_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      cnt_q         <= '0;
      size_limit_q  <= '0;
      drop_newest_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bfd_pkg::REG_SIZE_LIMIT:  size_limit_q  <= cfg_data_i;
          bfd_pkg::REG_DROP_NEWEST: drop_newest_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= in_data_i;
    end
    if (cmd_i.fin_exec || cmd_i.fin_read) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      item_mem[wr_addr] <= wr_item;
    end
    if (ab_we) begin
      aband_mem[ab_addr] <= ab_wd;
    end
    if (rd_en) begin
      rd_item_q  <= item_mem[rd_addr];
      rd_aband_q <= aband_mem[rd_addr];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/bounded_fifo_with_drop.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------
// in       | in_valid_i/in_ready_o | in_data_i   action, item_in, slot_in
// out      | out_valid_o/out_ready_i | out_data_o status .. entry_count
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// push into a non-full queue, cancel and pop of an empty queue: take in idle, then the exec step
// push into a full queue and pop: take, exec, then the read step, with a further skip read for each
//   abandoned entry skipped, set by the single registered read port of the item store
// one item in flight; the next item is taken while a result waits in the output register
// reset clears pointers, count and config at once; no clearing pass over the store
// a stalled output holds the block in its final step until the result can be loaded

`default_nettype none

module bounded_fifo_with_drop #(
  parameter int unsigned DEPTH      = bfd_pkg::BFD_DEPTH,
  parameter int unsigned ITEM_WIDTH = bfd_pkg::BFD_ITEM_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire bfd_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bfd_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bfd_pkg::cmd_t cmd;
  bfd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfd_datapath #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// ===== hdl/bfd_checker.sv =====
`default_nettype none

module bfd_port_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire bfd_pkg::out_item_t out_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while another is at work");

  // a drop only comes with a completed push
  a_drop_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.dropped_valid |->
      out_data_i.status == bfd_pkg::STS_DONE && out_data_i.item_out == '0)
    else $error("drop reported outside a push");

  // an empty pop leaves nothing queued
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == bfd_pkg::STS_EMPTY |->
      out_data_i.entry_count == '0 && out_data_i.item_out == '0 &&
      !out_data_i.dropped_valid)
    else $error("empty pop with entries left");

endmodule

bind bounded_fifo_with_drop bfd_port_checker u_bfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

// ===== tb/sv/bfd_checker.sv =====
`timescale 1ns / 100ps

module bfd_checker
  import bfd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire in_item_t              in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire out_item_t             out_data_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         waiting_o,
  output int                         checked_o
);

  // shadow copy of the queue
  logic [WORD_W-1:0]    words [BFD_DEPTH];
  bit   [BFD_DEPTH-1:0] dead_slots = '0;
  bit   [BFD_DEPTH-1:0] live_slots = '0;
  logic [SLOT_W-1:0]    head_pos = '0;
  logic [SLOT_W-1:0]    tail_pos = '0;
  logic [COUNT_W-1:0]   held = '0;
  logic [COUNT_W-1:0]   limit_reg = '0;
  bit                   tail_drop = 1'b0;

  out_item_t due_results [$];

  initial begin
    errors_o  = 0;
    waiting_o = 0;
    checked_o = 0;
  end

  function automatic out_item_t queue_step(in_item_t op);
    out_item_t          res;
    logic [COUNT_W-1:0] cap;
    logic [SLOT_W-1:0]  victim;
    bit                 found;
    bit                 was_dead;
    res = '0;
    case (op.action)
      ACT_PUSH: begin
        cap = (limit_reg == 0 || limit_reg > BFD_DEPTH) ? COUNT_W'(BFD_DEPTH) : limit_reg;
        if (held >= cap && held > 0) begin
          if (tail_drop) begin
            victim = tail_pos - 1'b1;
            tail_pos = victim;
          end else begin
            victim = head_pos;
            head_pos = head_pos + 1'b1;
          end
          res.dropped_valid = 1'b1;
          res.dropped_item = words[victim];
          live_slots[victim] = 1'b0;
          dead_slots[victim] = 1'b0;
          held = held - 1'b1;
        end
        words[tail_pos] = op.item_in;
        live_slots[tail_pos] = 1'b1;
        dead_slots[tail_pos] = 1'b0;
        res.slot_out = tail_pos;
        tail_pos = tail_pos + 1'b1;
        held = held + 1'b1;
      end
      ACT_POP: begin
        found = 1'b0;
        while (held > 0 && !found) begin
          victim = head_pos;
          was_dead = dead_slots[victim];
          live_slots[victim] = 1'b0;
          dead_slots[victim] = 1'b0;
          head_pos = head_pos + 1'b1;
          held = held - 1'b1;
          if (!was_dead) begin
            res.item_out = words[victim];
            found = 1'b1;
          end
        end
        if (!found) res.status = STS_EMPTY;
      end
      ACT_CANCEL: begin
        if (live_slots[op.slot_in]) dead_slots[op.slot_in] = 1'b1;
        else res.status = STS_NO_SLOT;
      end
      default: ;
    endcase
    res.entry_count = held;
    return res;
  endfunction

  task automatic compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SIZE_LIMIT:  limit_reg = cfg_data_i;
          REG_DROP_NEWEST: tail_drop = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: %0h", out_data_i);
          errors_o++;
        end else begin
          want = due_results.pop_front();
          compare_field("status", want.status, out_data_i.status);
          compare_field("item_out", want.item_out, out_data_i.item_out);
          compare_field("slot_out", want.slot_out, out_data_i.slot_out);
          compare_field("dropped_valid", want.dropped_valid, out_data_i.dropped_valid);
          compare_field("dropped_item", want.dropped_item, out_data_i.dropped_item);
          compare_field("entry_count", want.entry_count, out_data_i.entry_count);
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) due_results.push_back(queue_step(in_data_i));
      waiting_o = due_results.size();
    end
  end

endmodule

// ===== tb/sv/bounded_fifo_with_drop_tb.sv =====
`timescale 1ns / 100ps

module bounded_fifo_with_drop_tb;
  import bfd_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 170;
  localparam int LONG_STALL     = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int errors;
  int waiting;
  int checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_req = 1'b0;
  int sent_by_action [4] = '{default: 0};
  int settings = 0;
  int quiet = 0;

  logic [SLOT_W-1:0] recent_slots [8] = '{default: '0};

  bounded_fifo_with_drop uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  bfd_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .waiting_o   (waiting),
    .checked_o   (checked)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    int  stall_left;
    bit  stall_taken;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (stall_req && !stall_taken) begin
      stall_left = LONG_STALL;
      stall_taken = 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // remember slot_out of recent done results (pops and cancels give 0) so cancels mostly hit queued slots
  always @(posedge clk_i) begin
    int wr_ptr;
    if (out_valid_o && out_ready_i && out_data_o.status == STS_DONE) begin
      recent_slots[wr_ptr] = out_data_o.slot_out;
      wr_ptr = (wr_ptr + 1) % 8;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results outstanding", quiet, waiting);
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_op(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] word,
                         logic [SLOT_W-1:0] slot);
    in_item_t op;
    op.action  = act;
    op.item_in = word;
    op.slot_in = slot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    sent_by_action[act]++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (waiting != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_mode(logic [CFG_DATA_W-1:0] limit, bit newest);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(REG_SIZE_LIMIT, limit);
    write_reg(REG_DROP_NEWEST, CFG_DATA_W'(newest));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    settings++;
  endtask

  task automatic send_random(int push_pct);
    int                  roll;
    logic [ACTION_W-1:0] act;
    logic [SLOT_W-1:0]   slot;
    roll = $urandom_range(99);
    if (roll < 3) act = ACT_NONE;
    else if (roll < 3 + push_pct) act = ACT_PUSH;
    else if (roll < 3 + push_pct + (97 - push_pct) * 3 / 5) act = ACT_POP;
    else act = ACT_CANCEL;
    if ($urandom_range(3) != 0) slot = recent_slots[$urandom_range(7)];
    else slot = SLOT_W'($urandom_range(63));
    send_op(act, $urandom(), slot);
  endtask

  initial begin
    int lim_tab  [PHASES];
    int drop_tab [PHASES];
    int push_tab [PHASES];
    lim_tab  = '{0, 64, 1, 3, 17, 64, 2, 0, 5};
    drop_tab = '{0, 1, 0, 1, 0, 0, 1, 1, 0};
    push_tab = '{70, 70, 45, 45, 55, 60, 45, 60, 40};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SIZE_LIMIT;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // head drop with a small limit, cancels and pops over abandoned entries
    set_mode(4, 1'b0);
    send_op(ACT_PUSH, 32'h0000_0000, '0);
    send_op(ACT_PUSH, 32'hFFFF_FFFF, '0);
    send_op(ACT_PUSH, 32'hA5A5_A5A5, '0);
    send_op(ACT_PUSH, 32'h5A5A_5A5A, '0);
    send_op(ACT_PUSH, 32'h1234_5678, '0);
    send_op(ACT_CANCEL, '0, 6'd1);
    send_op(ACT_CANCEL, '0, 6'd1);
    send_op(ACT_CANCEL, '0, 6'd63);
    send_op(ACT_CANCEL, '0, 6'd0);
    send_op(ACT_PUSH, 32'hDEAD_BEEF, '0);
    send_op(ACT_CANCEL, '0, 6'd2);
    send_op(ACT_CANCEL, '0, 6'd3);
    send_op(ACT_POP, '0, '0);
    send_op(ACT_POP, '0, '0);
    send_op(ACT_POP, '0, '0);
    send_op(ACT_NONE, 32'hFFFF_FFFF, 6'd63);
    send_op(ACT_PUSH, 32'h0000_0001, '0);
    send_op(ACT_CANCEL, '0, 6'd6);
    send_op(ACT_POP, '0, '0);
    // tail drop reuses the slot of the newest entry
    set_mode(2, 1'b1);
    send_op(ACT_PUSH, 32'h8000_0000, '0);
    send_op(ACT_PUSH, 32'h7FFF_FFFF, '0);
    send_op(ACT_PUSH, 32'h0F0F_0F0F, '0);
    // limit now below the count
    set_mode(1, 1'b1);
    send_op(ACT_PUSH, 32'h3333_3333, '0);
    send_op(ACT_POP, '0, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode(CFG_DATA_W'(lim_tab[ph]), drop_tab[ph][0]);
      if (ph < 3) begin
        send_idle_pct = 30;
        recv_idle_pct <= 48;
      end else if (ph < 6) begin
        send_idle_pct = 48;
        recv_idle_pct <= 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 40) stall_req <= 1'b1;
        if (ph == 4 && k == 80) drain();
        send_random(push_tab[ph]);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("covered %0d pushes, %0d pops, %0d cancels, %0d ignored items over %0d settings",
             sent_by_action[ACT_PUSH], sent_by_action[ACT_POP], sent_by_action[ACT_CANCEL],
             sent_by_action[ACT_NONE], settings);
    $display("%0d results compared, %0d mismatches", checked, errors);
    if (errors == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
